>>> rtl/sixteen_bit_instruction_decoder_unit_assert.svh
// Assertion macros for the instruction decoder unit.
// Expects a clock named clock and a reset named reset in the using module.
`ifndef SIXTEEN_BIT_INSTRUCTION_DECODER_UNIT_ASSERT_SVH
`define SIXTEEN_BIT_INSTRUCTION_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define SBID_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sbid assertion failed");

`define SBID_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sbid assertion failed");

`else

`define SBID_ASSERT_IMPLIES(label, ante, cons)

`define SBID_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/sbid_pkg.sv
// Types and codes shared by the instruction decoder unit.
// No dependencies.
`timescale 1ns / 1ps

package sbid_pkg;

   typedef enum logic [4:0] {
      MN_FILL    = 5'd0,
      MN_NOP     = 5'd1,
      MN_BR      = 5'd2,
      MN_ADD     = 5'd3,
      MN_ADDI    = 5'd4,
      MN_MUL     = 5'd5,
      MN_SUB     = 5'd6,
      MN_DIV     = 5'd7,
      MN_CMP     = 5'd8,
      MN_CMPU    = 5'd9,
      MN_CMPI    = 5'd10,
      MN_CMPIU   = 5'd11,
      MN_JSR     = 5'd12,
      MN_JSRR    = 5'd13,
      MN_AND     = 5'd14,
      MN_ANDI    = 5'd15,
      MN_NOT     = 5'd16,
      MN_OR      = 5'd17,
      MN_XOR     = 5'd18,
      MN_LDR     = 5'd19,
      MN_STR     = 5'd20,
      MN_RTI     = 5'd21,
      MN_CONST   = 5'd22,
      MN_SLL     = 5'd23,
      MN_SRA     = 5'd24,
      MN_SRL     = 5'd25,
      MN_MOD     = 5'd26,
      MN_JMPR    = 5'd27,
      MN_JMP     = 5'd28,
      MN_HICONST = 5'd29,
      MN_TRAP    = 5'd30,
      MN_ILLEGAL = 5'd31
   } mnemonic_type;

   localparam logic [3:0] OP_BR      = 4'h0;
   localparam logic [3:0] OP_ARITH   = 4'h1;
   localparam logic [3:0] OP_CMP     = 4'h2;
   localparam logic [3:0] OP_JSR     = 4'h4;
   localparam logic [3:0] OP_LOGIC   = 4'h5;
   localparam logic [3:0] OP_LDR     = 4'h6;
   localparam logic [3:0] OP_STR     = 4'h7;
   localparam logic [3:0] OP_RTI     = 4'h8;
   localparam logic [3:0] OP_CONST   = 4'h9;
   localparam logic [3:0] OP_SHIFT   = 4'hA;
   localparam logic [3:0] OP_JMP     = 4'hC;
   localparam logic [3:0] OP_HICONST = 4'hD;
   localparam logic [3:0] OP_TRAP    = 4'hF;

   localparam logic [1:0] SUB_ADD = 2'd0;
   localparam logic [1:0] SUB_MUL = 2'd1;
   localparam logic [1:0] SUB_SUB = 2'd2;
   localparam logic [1:0] SUB_DIV = 2'd3;

   localparam logic [1:0] SUB_AND = 2'd0;
   localparam logic [1:0] SUB_NOT = 2'd1;
   localparam logic [1:0] SUB_OR  = 2'd2;
   localparam logic [1:0] SUB_XOR = 2'd3;

   localparam logic [1:0] SUB_CMP   = 2'd0;
   localparam logic [1:0] SUB_CMPU  = 2'd1;
   localparam logic [1:0] SUB_CMPI  = 2'd2;
   localparam logic [1:0] SUB_CMPIU = 2'd3;

   localparam logic [1:0] SUB_SLL = 2'd0;
   localparam logic [1:0] SUB_SRA = 2'd1;
   localparam logic [1:0] SUB_SRL = 2'd2;
   localparam logic [1:0] SUB_MOD = 2'd3;

   typedef struct packed {
      logic [15:0] word_address;
      logic [15:0] instruction_word;
   } req_word_type;

   typedef struct packed {
      mnemonic_type       mnemonic;
      logic [2:0]         branch_condition;
      logic [2:0]         dest_register;
      logic [2:0]         source_register;
      logic [2:0]         second_register;
      logic signed [15:0] immediate_value;
      logic [15:0]        target_address;
      logic               target_valid;
   } rsp_word_type;

endpackage

>>> rtl/sbid_req_if.sv
// Request channel: address and instruction word with valid/ready.
// Depends on sbid_pkg.
`timescale 1ns / 1ps

interface sbid_req_if;
   logic                  valid;
   logic                  ready;
   sbid_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/sbid_rsp_if.sv
// Response channel: decoded instruction word with valid/ready.
// Depends on sbid_pkg.
`timescale 1ns / 1ps

interface sbid_rsp_if;
   logic                  valid;
   logic                  ready;
   sbid_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/sbid_decode.sv
// Combinational decode of one address/instruction word into its fields.
// Depends on sbid_pkg.
`timescale 1ns / 1ps

module sbid_decode (
   input  sbid_pkg::req_word_type req_word,
   output sbid_pkg::rsp_word_type rsp_word
);

   logic [15:0] addr;
   logic [15:0] w;
   logic [15:0] imm9;
   logic [15:0] imm11;

   assign addr  = req_word.word_address;
   assign w     = req_word.instruction_word;
   assign imm9  = {{7{w[8]}}, w[8:0]};
   assign imm11 = {{5{w[10]}}, w[10:0]};

   always_comb begin
      rsp_word                  = '0;
      rsp_word.mnemonic         = sbid_pkg::MN_ILLEGAL;
      if (addr inside {[16'h2000:16'h7FFF], [16'hA000:16'hFFFF]}) begin
         rsp_word.mnemonic        = sbid_pkg::MN_FILL;
         rsp_word.immediate_value = w;
      end else begin
         case (w[15:12])
            sbid_pkg::OP_BR: begin
               rsp_word.branch_condition = w[11:9];
               rsp_word.immediate_value  = imm9;
               if (w[11:9] == 3'd0) begin
                  rsp_word.mnemonic = sbid_pkg::MN_NOP;
               end else begin
                  rsp_word.mnemonic       = sbid_pkg::MN_BR;
                  rsp_word.target_address = addr + 16'd1 + imm9;
                  rsp_word.target_valid   = 1'b1;
               end
            end
            sbid_pkg::OP_ARITH: begin
               rsp_word.dest_register   = w[11:9];
               rsp_word.source_register = w[8:6];
               if (w[5]) begin
                  rsp_word.mnemonic        = sbid_pkg::MN_ADDI;
                  rsp_word.immediate_value = {{11{w[4]}}, w[4:0]};
               end else begin
                  rsp_word.second_register = w[2:0];
                  case (w[4:3])
                     sbid_pkg::SUB_ADD: rsp_word.mnemonic = sbid_pkg::MN_ADD;
                     sbid_pkg::SUB_MUL: rsp_word.mnemonic = sbid_pkg::MN_MUL;
                     sbid_pkg::SUB_SUB: rsp_word.mnemonic = sbid_pkg::MN_SUB;
                     default:           rsp_word.mnemonic = sbid_pkg::MN_DIV;
                  endcase
               end
            end
            sbid_pkg::OP_LOGIC: begin
               rsp_word.dest_register   = w[11:9];
               rsp_word.source_register = w[8:6];
               if (w[5]) begin
                  rsp_word.mnemonic        = sbid_pkg::MN_ANDI;
                  rsp_word.immediate_value = {{11{w[4]}}, w[4:0]};
               end else begin
                  rsp_word.second_register = w[2:0];
                  case (w[4:3])
                     sbid_pkg::SUB_AND: rsp_word.mnemonic = sbid_pkg::MN_AND;
                     sbid_pkg::SUB_NOT: begin
                        rsp_word.mnemonic        = sbid_pkg::MN_NOT;
                        rsp_word.second_register = 3'd0;
                     end
                     sbid_pkg::SUB_OR:  rsp_word.mnemonic = sbid_pkg::MN_OR;
                     default:           rsp_word.mnemonic = sbid_pkg::MN_XOR;
                  endcase
               end
            end
            sbid_pkg::OP_CMP: begin
               rsp_word.source_register = w[11:9];
               case (w[8:7])
                  sbid_pkg::SUB_CMP: begin
                     rsp_word.mnemonic        = sbid_pkg::MN_CMP;
                     rsp_word.second_register = w[2:0];
                  end
                  sbid_pkg::SUB_CMPU: begin
                     rsp_word.mnemonic        = sbid_pkg::MN_CMPU;
                     rsp_word.second_register = w[2:0];
                  end
                  sbid_pkg::SUB_CMPI: begin
                     rsp_word.mnemonic        = sbid_pkg::MN_CMPI;
                     rsp_word.immediate_value = {{9{w[6]}}, w[6:0]};
                  end
                  default: begin
                     rsp_word.mnemonic        = sbid_pkg::MN_CMPIU;
                     rsp_word.immediate_value = {9'd0, w[6:0]};
                  end
               endcase
            end
            sbid_pkg::OP_JSR: begin
               if (w[11]) begin
                  rsp_word.mnemonic        = sbid_pkg::MN_JSR;
                  rsp_word.immediate_value = imm11;
                  rsp_word.target_address  = {addr[15], w[10:0], 4'd0};
                  rsp_word.target_valid    = 1'b1;
               end else begin
                  rsp_word.mnemonic        = sbid_pkg::MN_JSRR;
                  rsp_word.source_register = w[8:6];
               end
            end
            sbid_pkg::OP_LDR, sbid_pkg::OP_STR: begin
               rsp_word.mnemonic        = (w[15:12] == sbid_pkg::OP_LDR) ?
                                          sbid_pkg::MN_LDR : sbid_pkg::MN_STR;
               rsp_word.dest_register   = w[11:9];
               rsp_word.source_register = w[8:6];
               rsp_word.immediate_value = {{10{w[5]}}, w[5:0]};
            end
            sbid_pkg::OP_RTI: begin
               rsp_word.mnemonic = sbid_pkg::MN_RTI;
            end
            sbid_pkg::OP_CONST: begin
               rsp_word.mnemonic        = sbid_pkg::MN_CONST;
               rsp_word.dest_register   = w[11:9];
               rsp_word.immediate_value = imm9;
            end
            sbid_pkg::OP_SHIFT: begin
               rsp_word.dest_register   = w[11:9];
               rsp_word.source_register = w[8:6];
               case (w[5:4])
                  sbid_pkg::SUB_MOD: begin
                     rsp_word.mnemonic        = sbid_pkg::MN_MOD;
                     rsp_word.second_register = w[2:0];
                  end
                  sbid_pkg::SUB_SLL: begin
                     rsp_word.mnemonic        = sbid_pkg::MN_SLL;
                     rsp_word.immediate_value = {12'd0, w[3:0]};
                  end
                  sbid_pkg::SUB_SRA: begin
                     rsp_word.mnemonic        = sbid_pkg::MN_SRA;
                     rsp_word.immediate_value = {12'd0, w[3:0]};
                  end
                  default: begin
                     rsp_word.mnemonic        = sbid_pkg::MN_SRL;
                     rsp_word.immediate_value = {12'd0, w[3:0]};
                  end
               endcase
            end
            sbid_pkg::OP_JMP: begin
               if (w[11]) begin
                  rsp_word.mnemonic        = sbid_pkg::MN_JMP;
                  rsp_word.immediate_value = imm11;
                  rsp_word.target_address  = addr + 16'd1 + imm11;
                  rsp_word.target_valid    = 1'b1;
               end else begin
                  rsp_word.mnemonic        = sbid_pkg::MN_JMPR;
                  rsp_word.source_register = w[8:6];
               end
            end
            sbid_pkg::OP_HICONST: begin
               rsp_word.mnemonic        = sbid_pkg::MN_HICONST;
               rsp_word.dest_register   = w[11:9];
               rsp_word.immediate_value = {8'd0, w[7:0]};
            end
            sbid_pkg::OP_TRAP: begin
               rsp_word.mnemonic        = sbid_pkg::MN_TRAP;
               rsp_word.immediate_value = {8'd0, w[7:0]};
            end
            default: begin
               rsp_word.mnemonic = sbid_pkg::MN_ILLEGAL;
            end
         endcase
      end
   end

endmodule

>>> rtl/sixteen_bit_instruction_decoder_unit.sv
// Instruction decoder unit, top level: input register, decode, result register.
// Depends on sbid_pkg, sbid_req_if, sbid_rsp_if, sbid_decode and the assert header.
//
// Decodes one 16-bit word per cycle while rsp_port takes results, given with its
// address, into mnemonic, branch condition, register numbers, extended immediate
// and branch/jump target. A word accepted on req_port sits in the input register
// while the decode logic works on it, and its result is then captured in the
// result register and presented on rsp_port. The input stage takes a word
// whenever it is empty or the result register takes its word, so a new word is
// taken every cycle while rsp_port keeps taking results, and one more word is
// held while a result waits.
`timescale 1ns / 1ps
`include "sixteen_bit_instruction_decoder_unit_assert.svh"

module sixteen_bit_instruction_decoder_unit (
   input logic        clock,
   input logic        reset,
   sbid_req_if.sink   req_port,
   sbid_rsp_if.source rsp_port
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   sbid_pkg::req_word_type in_data_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   sbid_pkg::rsp_word_type out_data_ff;
   sbid_pkg::rsp_word_type decoded;
   logic                   out_take;
   logic                   in_take;

   assign out_take = !out_valid_ff || rsp_port.ready;
   assign in_take  = !in_valid_ff || out_take;

   assign req_port.ready = in_take;
   assign rsp_port.valid = out_valid_ff;
   assign rsp_port.data  = out_data_ff;

   assign in_valid_in  = in_take ? req_port.valid : in_valid_ff;
   assign out_valid_in = out_take ? in_valid_ff : out_valid_ff;

   sbid_decode u_decode (
      .req_word (in_data_ff),
      .rsp_word (decoded)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && req_port.valid) begin
         in_data_ff <= req_port.data;
      end
      if (out_take && in_valid_ff) begin
         out_data_ff <= decoded;
      end
   end

   `SBID_ASSERT_IMPLIES(a_target_kind, out_valid_ff && out_data_ff.target_valid,
      out_data_ff.mnemonic == sbid_pkg::MN_BR || out_data_ff.mnemonic == sbid_pkg::MN_JMP ||
      out_data_ff.mnemonic == sbid_pkg::MN_JSR)
   `SBID_ASSERT_IMPLIES(a_illegal_clear,
      out_valid_ff && out_data_ff.mnemonic == sbid_pkg::MN_ILLEGAL,
      out_data_ff.target_valid == 1'b0 && out_data_ff.immediate_value == 16'sd0 &&
      out_data_ff.dest_register == 3'd0)
   `SBID_ASSERT_NEXT(a_in_hold, in_valid_ff && !out_take, in_valid_ff && $stable(in_data_ff))
   `SBID_ASSERT_NEXT(a_advance, in_valid_ff && out_take, out_valid_ff)

endmodule
